>>> rtl/breathing_led_color_generator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the breathing LED color generator
// Shared helpers that wrap concurrent assertions on clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef BREATHING_LED_COLOR_GENERATOR_MACROS_SVH
`define BREATHING_LED_COLOR_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BLCG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/blcg_pkg.sv
// ---------------------------------------------------------------------------
// blcg_pkg
// Types, codes and helper functions shared by the color generator modules.
// ---------------------------------------------------------------------------
package blcg_pkg;

  // Width of the period and of the reduced time.
  localparam int PW = 34;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [1:0] PH_RISE = 2'd0;
  localparam logic [1:0] PH_TOP  = 2'd1;
  localparam logic [1:0] PH_FALL = 2'd2;
  localparam logic [1:0] PH_REST = 2'd3;

  localparam logic [2:0] REG_HUE  = 3'd0;
  localparam logic [2:0] REG_SAT  = 3'd1;
  localparam logic [2:0] REG_MIN  = 3'd2;
  localparam logic [2:0] REG_MAX  = 3'd3;
  localparam logic [2:0] REG_RAMP = 3'd4;
  localparam logic [2:0] REG_HOLD = 3'd5;

  typedef struct packed {
    logic [PW-1:0] period;
    logic [31:0]   ramp;
    logic [32:0]   top_end;
    logic [PW-1:0] fall_end;
  } env_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] num;
  } item_t;

  typedef struct packed {
    logic [31:0] ramp;
    logic [7:0]  range;
    logic [7:0]  min_level;
    logic [7:0]  max_level;
  } lvl_t;

  typedef struct packed {
    logic       sat_zero;
    logic [2:0] sector;
    logic [7:0] ps;
    logic [7:0] qs;
    logic [7:0] ts;
  } hsv_t;

  function automatic logic [2:0] hue_sector(input logic [7:0] h);
    logic [2:0] s;
    if (h < 8'd43) s = 3'd0;
    else if (h < 8'd86) s = 3'd1;
    else if (h < 8'd129) s = 3'd2;
    else if (h < 8'd172) s = 3'd3;
    else if (h < 8'd215) s = 3'd4;
    else s = 3'd5;
    return s;
  endfunction

  function automatic logic [7:0] sector_base(input logic [2:0] s);
    logic [7:0] b;
    case (s)
      3'd0: b = 8'd0;
      3'd1: b = 8'd43;
      3'd2: b = 8'd86;
      3'd3: b = 8'd129;
      3'd4: b = 8'd172;
      default: b = 8'd215;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/blcg_front.sv
// ---------------------------------------------------------------------------
// blcg_front
// Reduces each timestamp modulo the period, one bit per stage, and classifies
// the result into a phase and a ramp offset.
// ---------------------------------------------------------------------------
module blcg_front import blcg_pkg::*; #(
  parameter int TW = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [TW-1:0] in_time,
  output logic          in_ready,
  input  env_t          env,
  input  logic          q_full,
  output logic          push,
  output item_t         push_item
);

  logic          vld_r [TW];
  logic [PW-1:0] rem_r [TW];
  logic [TW-1:0] dvd_r [TW];
  logic          adv;
  logic [PW-1:0] t;

  assign adv      = !vld_r[TW-1] || !q_full;
  assign in_ready = adv;

  for (genvar i = 0; i < TW; i++) begin : g_stage
    logic [PW-1:0] rin;
    logic [TW-1:0] din;
    logic          vin;
    logic [PW:0]   sh;

    if (i == 0) begin : g_first
      assign rin = '0;
      assign din = in_time;
      assign vin = in_valid;
    end else begin : g_rest
      assign rin = rem_r[i-1];
      assign din = dvd_r[i-1];
      assign vin = vld_r[i-1];
    end

    assign sh = {rin, din[TW-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (sh >= {1'b0, env.period}) begin
          rem_r[i] <= PW'(sh - {1'b0, env.period});
        end else begin
          rem_r[i] <= sh[PW-1:0];
        end
        dvd_r[i] <= din << 1;
      end
    end
  end

  assign t    = rem_r[TW-1];
  assign push = vld_r[TW-1] && !q_full;

  always_comb begin
    push_item = '0;
    if (t <= {2'b0, env.ramp}) begin
      push_item.phase = PH_RISE;
      push_item.num   = t[31:0];
    end else if (t <= {1'b0, env.top_end}) begin
      push_item.phase = PH_TOP;
    end else if (t <= env.fall_end) begin
      push_item.phase = PH_FALL;
      push_item.num   = 32'(t - {1'b0, env.top_end});
    end else begin
      push_item.phase = PH_REST;
    end
  end

endmodule

>>> rtl/blcg_queue.sv
// ---------------------------------------------------------------------------
// blcg_queue
// Short first-in first-out buffer between the front and the back part.
// ---------------------------------------------------------------------------
module blcg_queue import blcg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t pop_item,
  output logic  full,
  output logic  empty
);

  item_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt;
  logic [Q_AW-1:0] rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

>>> rtl/blcg_back.sv
// ---------------------------------------------------------------------------
// blcg_back
// Scales the ramp offset into a brightness level with a pipelined divider
// and converts hue, saturation and level into RGB.
// ---------------------------------------------------------------------------
module blcg_back import blcg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  input  item_t      pop_item,
  output logic       pop,
  input  lvl_t       lvl,
  input  hsv_t       hsv,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [1:0] out_phase,
  output logic [7:0] out_level
);

  logic        adv;
  logic        m_vld_r;
  logic [39:0] m_prod_r;
  logic [1:0]  m_ph_r;
  logic        d_vld_r  [8];
  logic [39:0] d_rem_r  [8];
  logic [7:0]  d_q_r    [8];
  logic [1:0]  d_ph_r   [8];
  logic        l_vld_r;
  logic [7:0]  l_lvl_r;
  logic [1:0]  l_ph_r;
  logic [7:0]  lvl_nxt;
  logic [15:0] p_prod, q_prod, t_prod;
  logic [7:0]  r_nxt, g_nxt, b_nxt, v, p, q, tt;
  logic        o_vld_r;
  logic [7:0]  o_r_r, o_g_r, o_b_r, o_lvl_r;
  logic [1:0]  o_ph_r;

  assign adv = !o_vld_r || out_ready;
  assign pop = adv && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_prod_r <= {32'd0, lvl.range} * {8'd0, pop_item.num};
      m_ph_r   <= pop_item.phase;
    end
  end

  // Restoring division by the ramp: the quotient never exceeds 255.
  for (genvar j = 0; j < 8; j++) begin : g_div
    logic        vin;
    logic [39:0] rin;
    logic [7:0]  qin;
    logic [1:0]  phin;
    logic [40:0] dsh;

    if (j == 0) begin : g_first
      assign vin  = m_vld_r;
      assign rin  = m_prod_r;
      assign qin  = '0;
      assign phin = m_ph_r;
    end else begin : g_rest
      assign vin  = d_vld_r[j-1];
      assign rin  = d_rem_r[j-1];
      assign qin  = d_q_r[j-1];
      assign phin = d_ph_r[j-1];
    end

    assign dsh = 41'({lvl.ramp, 7'b0} >> j);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_vld_r[j] <= 1'b0;
      end else if (adv) begin
        d_vld_r[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_ph_r[j] <= phin;
        if ({1'b0, rin} >= dsh) begin
          d_rem_r[j] <= 40'({1'b0, rin} - dsh);
          d_q_r[j]   <= qin | (8'h80 >> j);
        end else begin
          d_rem_r[j] <= rin;
          d_q_r[j]   <= qin;
        end
      end
    end
  end

  always_comb begin
    case (d_ph_r[7])
      PH_RISE: lvl_nxt = d_q_r[7] + lvl.min_level;
      PH_TOP:  lvl_nxt = lvl.max_level;
      PH_FALL: lvl_nxt = lvl.max_level - d_q_r[7];
      default: lvl_nxt = lvl.min_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_vld_r <= 1'b0;
    end else if (adv) begin
      l_vld_r <= d_vld_r[7];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_lvl_r <= lvl_nxt;
      l_ph_r  <= d_ph_r[7];
    end
  end

  assign v      = l_lvl_r;
  assign p_prod = {8'd0, v} * {8'd0, hsv.ps};
  assign q_prod = {8'd0, v} * {8'd0, hsv.qs};
  assign t_prod = {8'd0, v} * {8'd0, hsv.ts};
  assign p      = p_prod[15:8];
  assign q      = q_prod[15:8];
  assign tt     = t_prod[15:8];

  always_comb begin
    if (hsv.sat_zero) begin
      r_nxt = v; g_nxt = v; b_nxt = v;
    end else begin
      case (hsv.sector)
        3'd0: begin r_nxt = v;  g_nxt = tt; b_nxt = p;  end
        3'd1: begin r_nxt = q;  g_nxt = v;  b_nxt = p;  end
        3'd2: begin r_nxt = p;  g_nxt = v;  b_nxt = tt; end
        3'd3: begin r_nxt = p;  g_nxt = q;  b_nxt = v;  end
        3'd4: begin r_nxt = tt; g_nxt = p;  b_nxt = v;  end
        default: begin r_nxt = v; g_nxt = p; b_nxt = q; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= l_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_r_r   <= r_nxt;
      o_g_r   <= g_nxt;
      o_b_r   <= b_nxt;
      o_ph_r  <= l_ph_r;
      o_lvl_r <= l_lvl_r;
    end
  end

  assign out_valid = o_vld_r;
  assign out_red   = o_r_r;
  assign out_green = o_g_r;
  assign out_blue  = o_b_r;
  assign out_phase = o_ph_r;
  assign out_level = o_lvl_r;

endmodule

>>> rtl/breathing_led_color_generator.sv
// Throughput: one word per cycle unless out_ready or a full queue stalls the
// pipeline; the modulo stage reduces one time bit per pipeline stage and the
// level divider resolves one quotient bit per stage.
// Reset (synchronous, rst_n low) empties the pipelines and the queue and loads
// the register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
// breathing_led_color_generator
// Breathing envelope over a free-running time with HSV to RGB conversion.
// ---------------------------------------------------------------------------
`include "breathing_led_color_generator_macros.svh"

module breathing_led_color_generator import blcg_pkg::*; #(
  parameter int TIME_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_time_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [1:0]  out_phase,
  output logic [7:0]  out_level,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [7:0]  hue_r, sat_r, min_r, max_r;
  logic [31:0] ramp_r, hold_r;
  logic [31:0] ramp_eff;
  env_t        env;
  lvl_t        lvl;
  hsv_t        hsv_r;
  logic [2:0]  sector;
  logic [7:0]  frac;
  logic [7:0]  hdiff;
  logic [15:0] sf_q, sf_t;
  logic        push, pop, q_full, q_empty;
  item_t       push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r  <= 8'd0;
      sat_r  <= 8'd0;
      min_r  <= 8'd0;
      max_r  <= 8'd255;
      ramp_r <= 32'd500000;
      hold_r <= 32'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HUE:  hue_r  <= cfg_data[7:0];
        REG_SAT:  sat_r  <= cfg_data[7:0];
        REG_MIN:  min_r  <= cfg_data[7:0];
        REG_MAX:  max_r  <= cfg_data[7:0];
        REG_RAMP: ramp_r <= cfg_data;
        REG_HOLD: hold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ramp_eff     = (ramp_r == '0) ? 32'd1 : ramp_r;
  assign env.ramp     = ramp_eff;
  assign env.top_end  = {1'b0, ramp_eff} + {1'b0, hold_r};
  assign env.period   = {env.top_end, 1'b0};
  assign env.fall_end = {1'b0, env.top_end} + {2'b0, ramp_eff};

  assign lvl.ramp      = ramp_eff;
  assign lvl.range     = max_r - min_r;
  assign lvl.min_level = min_r;
  assign lvl.max_level = max_r;

  // The color coefficients depend only on hue and saturation, so they are
  // registered here once instead of being recomputed per word.
  assign sector = hue_sector(hue_r);
  assign hdiff  = hue_r - sector_base(sector);
  assign frac   = 8'(hdiff * 8'd6);
  assign sf_q   = {8'd0, sat_r} * {8'd0, frac};
  assign sf_t   = {8'd0, sat_r} * {8'd0, 8'd255 - frac};

  always_ff @(posedge clk) begin
    hsv_r.sat_zero <= (sat_r == '0);
    hsv_r.sector   <= sector;
    hsv_r.ps       <= 8'd255 - sat_r;
    hsv_r.qs       <= 8'd255 - sf_q[15:8];
    hsv_r.ts       <= 8'd255 - sf_t[15:8];
  end

  blcg_front #(.TW(TIME_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_time   (in_time_us[TIME_WIDTH-1:0]),
    .in_ready  (in_ready),
    .env       (env),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  blcg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  blcg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (!q_empty),
    .pop_item  (pop_item),
    .pop       (pop),
    .lvl       (lvl),
    .hsv       (hsv_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_phase (out_phase),
    .out_level (out_level)
  );

  `BLCG_ASSERT_SAME(a_top_level, out_valid && out_phase == PH_TOP, out_level == max_r, "top hold level differs from max_level")
  `BLCG_ASSERT_SAME(a_rest_level, out_valid && out_phase == PH_REST, out_level == min_r, "rest level differs from min_level")
  `BLCG_ASSERT_SAME(a_gray, out_valid && sat_r == 8'd0, out_red == out_level && out_blue == out_level, "gray output differs from level")
  `BLCG_ASSERT_NEXT(a_no_push_full, q_full && !pop, !push || q_full, "queue accepted a word while full")

endmodule
